@@ hdl/cau_pkg.sv @@
`default_nettype none

package cau_pkg;

	// Data format: signed fixed point, W bits with FB fraction bits.
	localparam int W  = 32;
	localparam int FB = 16;
	// Exact product width, signed sum width and quotient bits per divide.
	localparam int PW = 2 * W;
	localparam int SW = PW + 1;
	localparam int QB = W + 1;
	// Numerator bits that sit above the quotient window.
	localparam int HB = QB - FB;

	typedef enum logic [2:0] {
		MODE_CADD = 3'd0,
		MODE_CSUB = 3'd1,
		MODE_CMUL = 3'd2,
		MODE_CDIV = 3'd3,
		MODE_SADD = 3'd4,
		MODE_SSUB = 3'd5,
		MODE_SMUL = 3'd6,
		MODE_SDIV = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_SAT = 2'd1,
		STAT_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		mode_t                mode;
		logic signed [W-1:0]  a_re;
		logic signed [W-1:0]  a_im;
		logic signed [W-1:0]  b_re;
		logic signed [W-1:0]  b_im;
	} req_t;

	typedef struct packed {
		logic signed [W-1:0]  res_re;
		logic signed [W-1:0]  res_im;
		status_t              status;
	} rsp_t;

	// Stage 1: products and plain sums.
	typedef struct packed {
		mode_t                mode;
		logic signed [W-1:0]  a;
		logic signed [W-1:0]  b;
		logic signed [W-1:0]  c;
		logic signed [PW-1:0] ac;
		logic signed [PW-1:0] bd;
		logic signed [PW-1:0] ad;
		logic signed [PW-1:0] bc;
		logic signed [PW-1:0] cc;
		logic signed [PW-1:0] dd;
		logic signed [W:0]    sum_re;
		logic signed [W:0]    sum_im;
	} s1_t;

	// Stage 2: numerators, divisor and result signs.
	typedef struct packed {
		mode_t                mode;
		logic signed [SW-1:0] n_re;
		logic signed [SW-1:0] n_im;
		logic [PW-1:0]        den;
		logic                 neg_re;
		logic                 neg_im;
		logic signed [W:0]    sum_re;
		logic signed [W:0]    sum_im;
	} s2_t;

	// Stage 3: magnitudes.
	typedef struct packed {
		mode_t                mode;
		logic [PW-1:0]        m_re;
		logic [PW-1:0]        m_im;
		logic [PW-1:0]        den;
		logic                 neg_re;
		logic                 neg_im;
		logic                 dz;
		logic signed [W:0]    sum_re;
		logic signed [W:0]    sum_im;
	} s3_t;

	// One lane of the restoring divider.
	typedef struct packed {
		logic [PW-1:0]        r;
		logic [QB-1:0]        n;
		logic [QB-1:0]        q;
	} dlane_t;

	// Divider stage contents; non-divide results ride along.
	typedef struct packed {
		mode_t                mode;
		logic                 dz;
		logic                 neg_re;
		logic                 neg_im;
		logic                 ovf_re;
		logic                 ovf_im;
		logic [PW-1:0]        den;
		dlane_t               l_re;
		dlane_t               l_im;
		logic [W-1:0]         fx_re;
		logic [W-1:0]         fx_im;
		logic                 fx_flag;
	} dstg_t;

	// Rounded quotients.
	typedef struct packed {
		mode_t                mode;
		logic                 dz;
		logic                 neg_re;
		logic                 neg_im;
		logic                 ovf_re;
		logic                 ovf_im;
		logic [QB:0]          qf_re;
		logic [QB:0]          qf_im;
		logic [W-1:0]         fx_re;
		logic [W-1:0]         fx_im;
		logic                 fx_flag;
	} rd_t;

endpackage

`default_nettype wire

@@ hdl/complex_arith_unit.sv @@
`default_nettype none

// Channel   Signals                       Direction   Contents
// cmd       cmd_valid, cmd_ready, cmd     in          mode and two complex operands
// rsp       rsp_valid, rsp_ready, rsp     out         complex result and status
//
// One request enters every cycle unless a stall holds the pipeline; each result passes stages 1 to 4,
// the restoring divider, one quotient bit per stage, 33 stages, and then stages 6 and 7.
// All stages advance together whenever the output register is empty or being taken.
// A stall freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears only the stage valid bits.
module complex_arith_unit
	import cau_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       cmd_valid,
	output logic      cmd_ready,
	input  wire req_t cmd,
	output logic      rsp_valid,
	input  wire       rsp_ready,
	output rsp_t      rsp
);

	// Saturate a sign and magnitude; returns the flag above the value.
	function automatic logic [W:0] sat_mag(input logic neg, input logic [SW-1:0] m);
		logic [SW-1:0] lim;
		logic [W-1:0]  v;
		logic          f;
		lim = (SW'(1) << (W - 1)) - SW'(!neg);
		if (m > lim) begin
			f = 1'b1;
			v = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			f = 1'b0;
			v = m[W-1:0];
			if (neg) begin
				v = -v;
			end
		end
		return {f, v};
	endfunction

	// Saturate a signed sum one bit wider than the result.
	function automatic logic [W:0] sat_sum(input logic signed [W:0] s);
		logic [W:0] a;
		a = s[W] ? -s : s;
		return sat_mag(s[W], SW'(a));
	endfunction

	// One restoring division step.
	function automatic dlane_t div_step(input dlane_t l, input logic [PW-1:0] d);
		logic [PW:0] rs;
		logic [PW:0] diff;
		dlane_t      o;
		rs   = {l.r, l.n[QB-1]};
		diff = rs - {1'b0, d};
		o.n  = {l.n[QB-2:0], 1'b0};
		if (rs >= {1'b0, d}) begin
			o.r = diff[PW-1:0];
			o.q = {l.q[QB-2:0], 1'b1};
		end else begin
			o.r = rs[PW-1:0];
			o.q = {l.q[QB-2:0], 1'b0};
		end
		return o;
	endfunction

	logic  adv;
	logic  v_s1, v_s2, v_s3, v_s4, v_s6, v_s7;
	s1_t   p_s1, p1_d;
	s2_t   p_s2, p2_d;
	s3_t   p_s3, p3_d;
	dstg_t p_s4, p4_d;
	logic  dvv_s5 [QB];
	dstg_t dv_s5  [QB];
	rd_t   rd_s6, rd_d;
	rsp_t  out_s7, out_d;

	// The whole pipeline moves when the output register can take a result.
	assign adv       = !v_s7 || rsp_ready;
	assign cmd_ready = adv;
	assign rsp_valid = v_s7;
	assign rsp       = out_s7;

	// Stage 1: the six products and the plain sums.
	always_comb begin
		logic sub;
		sub          = (cmd.mode == MODE_CSUB) || (cmd.mode == MODE_SSUB);
		p1_d.mode    = cmd.mode;
		p1_d.a       = cmd.a_re;
		p1_d.b       = cmd.a_im;
		p1_d.c       = cmd.b_re;
		p1_d.ac      = PW'(cmd.a_re) * PW'(cmd.b_re);
		p1_d.bd      = PW'(cmd.a_im) * PW'(cmd.b_im);
		p1_d.ad      = PW'(cmd.a_re) * PW'(cmd.b_im);
		p1_d.bc      = PW'(cmd.a_im) * PW'(cmd.b_re);
		p1_d.cc      = PW'(cmd.b_re) * PW'(cmd.b_re);
		p1_d.dd      = PW'(cmd.b_im) * PW'(cmd.b_im);
		p1_d.sum_re  = sub ? ((W+1)'(cmd.a_re) - (W+1)'(cmd.b_re))
		                   : ((W+1)'(cmd.a_re) + (W+1)'(cmd.b_re));
		if ((cmd.mode == MODE_SADD) || (cmd.mode == MODE_SSUB)) begin
			p1_d.sum_im = (W+1)'(cmd.a_im);
		end else begin
			p1_d.sum_im = sub ? ((W+1)'(cmd.a_im) - (W+1)'(cmd.b_im))
			                  : ((W+1)'(cmd.a_im) + (W+1)'(cmd.b_im));
		end
	end

	// Stage 2: numerators and divisor for the chosen operation.
	always_comb begin
		logic signed [PW-1:0] cx;
		cx          = PW'(p_s1.c);
		p2_d.mode   = p_s1.mode;
		p2_d.sum_re = p_s1.sum_re;
		p2_d.sum_im = p_s1.sum_im;
		p2_d.den    = p_s1.cc + p_s1.dd;
		case (p_s1.mode)
			MODE_CMUL: begin
				p2_d.n_re = SW'(p_s1.ac) - SW'(p_s1.bd);
				p2_d.n_im = SW'(p_s1.ad) + SW'(p_s1.bc);
			end
			MODE_CDIV: begin
				p2_d.n_re = SW'(p_s1.ac) + SW'(p_s1.bd);
				p2_d.n_im = SW'(p_s1.bc) - SW'(p_s1.ad);
			end
			MODE_SDIV: begin
				p2_d.n_re = SW'(p_s1.a);
				p2_d.n_im = SW'(p_s1.b);
				p2_d.den  = cx[PW-1] ? -cx : cx;
			end
			default: begin
				p2_d.n_re = SW'(p_s1.ac);
				p2_d.n_im = SW'(p_s1.bc);
			end
		endcase
		if (p_s1.mode == MODE_SDIV) begin
			p2_d.neg_re = p_s1.a[W-1] ^ p_s1.c[W-1];
			p2_d.neg_im = p_s1.b[W-1] ^ p_s1.c[W-1];
		end else begin
			p2_d.neg_re = p2_d.n_re[SW-1];
			p2_d.neg_im = p2_d.n_im[SW-1];
		end
	end

	// Stage 3: magnitudes and the zero divisor check.
	always_comb begin
		logic [SW-1:0] nr;
		logic [SW-1:0] ni;
		nr          = p_s2.n_re[SW-1] ? -p_s2.n_re : p_s2.n_re;
		ni          = p_s2.n_im[SW-1] ? -p_s2.n_im : p_s2.n_im;
		p3_d.mode   = p_s2.mode;
		p3_d.m_re   = nr[PW-1:0];
		p3_d.m_im   = ni[PW-1:0];
		p3_d.den    = p_s2.den;
		p3_d.neg_re = p_s2.neg_re;
		p3_d.neg_im = p_s2.neg_im;
		p3_d.sum_re = p_s2.sum_re;
		p3_d.sum_im = p_s2.sum_im;
		p3_d.dz     = ((p_s2.mode == MODE_CDIV) || (p_s2.mode == MODE_SDIV))
		              && (p_s2.den == '0);
	end

	// Stage 4: finish add and multiply results; set up the divider.
	always_comb begin
		logic [SW-1:0] rr;
		logic [SW-1:0] ri;
		logic [W:0]    sr;
		logic [W:0]    si;
		rr = ({1'b0, p_s3.m_re} + (SW'(1) << (FB - 1))) >> FB;
		ri = ({1'b0, p_s3.m_im} + (SW'(1) << (FB - 1))) >> FB;
		case (p_s3.mode)
			MODE_CMUL, MODE_SMUL: begin
				sr = sat_mag(p_s3.neg_re, rr);
				si = sat_mag(p_s3.neg_im, ri);
			end
			default: begin
				sr = sat_sum(p_s3.sum_re);
				si = sat_sum(p_s3.sum_im);
			end
		endcase
		p4_d.mode    = p_s3.mode;
		p4_d.dz      = p_s3.dz;
		p4_d.neg_re  = p_s3.neg_re;
		p4_d.neg_im  = p_s3.neg_im;
		p4_d.den     = p_s3.den;
		p4_d.fx_re   = sr[W-1:0];
		p4_d.fx_im   = si[W-1:0];
		p4_d.fx_flag = sr[W] | si[W];
		// A quotient of 2^QB or more always saturates.
		p4_d.ovf_re  = {{HB{1'b0}}, p_s3.m_re} >= {p_s3.den, {HB{1'b0}}};
		p4_d.ovf_im  = {{HB{1'b0}}, p_s3.m_im} >= {p_s3.den, {HB{1'b0}}};
		p4_d.l_re.r  = PW'(p_s3.m_re >> HB);
		p4_d.l_re.n  = {p_s3.m_re[HB-1:0], {FB{1'b0}}};
		p4_d.l_re.q  = '0;
		p4_d.l_im.r  = PW'(p_s3.m_im >> HB);
		p4_d.l_im.n  = {p_s3.m_im[HB-1:0], {FB{1'b0}}};
		p4_d.l_im.q  = '0;
	end

	// Stages 1 to 4.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= p1_d;
			p_s2 <= p2_d;
			p_s3 <= p3_d;
			p_s4 <= p4_d;
		end
	end

	// Divider: one quotient bit per stage for both lanes.
	for (genvar i = 0; i < QB; i++) begin : g_div
		dstg_t src;
		dstg_t nxt;
		logic  src_v;
		if (i == 0) begin : g_first
			assign src   = p_s4;
			assign src_v = v_s4;
		end else begin : g_rest
			assign src   = dv_s5[i-1];
			assign src_v = dvv_s5[i-1];
		end

		always_comb begin
			nxt      = src;
			nxt.l_re = div_step(src.l_re, src.den);
			nxt.l_im = div_step(src.l_im, src.den);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s5[i] <= 1'b0;
			end else if (adv) begin
				dvv_s5[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s5[i] <= nxt;
			end
		end
	end

	// Stage 6: round the quotients to nearest, ties away from zero.
	always_comb begin
		dstg_t l;
		logic  up_re;
		logic  up_im;
		l            = dv_s5[QB-1];
		up_re        = {l.l_re.r, 1'b0} >= {1'b0, l.den};
		up_im        = {l.l_im.r, 1'b0} >= {1'b0, l.den};
		rd_d.mode    = l.mode;
		rd_d.dz      = l.dz;
		rd_d.neg_re  = l.neg_re;
		rd_d.neg_im  = l.neg_im;
		rd_d.ovf_re  = l.ovf_re;
		rd_d.ovf_im  = l.ovf_im;
		rd_d.qf_re   = (QB+1)'(l.l_re.q) + (QB+1)'(up_re);
		rd_d.qf_im   = (QB+1)'(l.l_im.q) + (QB+1)'(up_im);
		rd_d.fx_re   = l.fx_re;
		rd_d.fx_im   = l.fx_im;
		rd_d.fx_flag = l.fx_flag;
	end

	// Stage 7: saturate quotients and pick the result.
	always_comb begin
		logic [W:0] qr;
		logic [W:0] qi;
		qr = sat_mag(rd_s6.neg_re, rd_s6.ovf_re ? {SW{1'b1}} : SW'(rd_s6.qf_re));
		qi = sat_mag(rd_s6.neg_im, rd_s6.ovf_im ? {SW{1'b1}} : SW'(rd_s6.qf_im));
		if (rd_s6.dz) begin
			out_d.res_re = '0;
			out_d.res_im = '0;
			out_d.status = STAT_DZ;
		end else if ((rd_s6.mode == MODE_CDIV) || (rd_s6.mode == MODE_SDIV)) begin
			out_d.res_re = qr[W-1:0];
			out_d.res_im = qi[W-1:0];
			out_d.status = (qr[W] | qi[W]) ? STAT_SAT : STAT_OK;
		end else begin
			out_d.res_re = rd_s6.fx_re;
			out_d.res_im = rd_s6.fx_im;
			out_d.status = rd_s6.fx_flag ? STAT_SAT : STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s6 <= dvv_s5[QB-1];
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s6  <= rd_d;
			out_s7 <= out_d;
		end
	end

	// Checks on the pipeline control and result coding.
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready == (!rsp_valid || rsp_ready))
		else $error("cmd_ready does not follow the output register");

	a_stall_holds_divider: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> ($stable(dvv_s5[QB-1]) && $stable(v_s6)))
		else $error("pipeline moved during a stall");

	a_dz_only_divide: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && rd_s6.dz) |-> ((rd_s6.mode == MODE_CDIV) || (rd_s6.mode == MODE_SDIV)))
		else $error("zero divisor flagged outside a divide");

	a_dz_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && rd_s6.dz && adv) |=> (rsp.status == STAT_DZ && rsp.res_re == '0
		&& rsp.res_im == '0))
		else $error("divide by zero result not cleared");

endmodule

`default_nettype wire

@@ bench/complex_arith_unit_checker.sv @@
module complex_arith_unit_checker
	import cau_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  cmd_valid,
	input  wire  cmd_ready,
	input  req_t cmd,
	input  wire  rsp_valid,
	input  wire  rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);

	rsp_t expected_q[$];

	// Clamp a signed value to the 32-bit range, raising the saturation flag.
	function automatic logic signed [31:0] clamp32(input logic signed [129:0] v,
			inout logic flag);
		if (v > 130'sd2147483647) begin
			flag = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -130'sd2147483648) begin
			flag = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Drop the fraction bits, rounding half away from zero.
	function automatic logic signed [31:0] round_fx(input logic signed [129:0] v,
			inout logic flag);
		logic signed [129:0] m;
		m = (v < 0) ? -v : v;
		m = (m + (130'sd1 <<< (FB - 1))) >>> FB;
		return clamp32((v < 0) ? -m : m, flag);
	endfunction

	// Quotient of num << FB over den, rounded half away from zero.
	function automatic logic signed [31:0] div_fx(input logic signed [129:0] num,
			input logic signed [129:0] den, inout logic flag);
		logic signed [129:0] n, d, q, r;
		logic neg;
		neg = (num < 0) != (den < 0);
		n = ((num < 0) ? -num : num) <<< FB;
		d = (den < 0) ? -den : den;
		q = n / d;
		r = n - q * d;
		if (r >= d - r)
			q = q + 1;
		return clamp32(neg ? -q : q, flag);
	endfunction

	// Work out the result a request must produce.
	function automatic rsp_t predict_result(input req_t r);
		rsp_t o;
		logic flag;
		logic signed [129:0] a, b, c, d, den;
		flag = 1'b0;
		a = r.a_re;
		b = r.a_im;
		c = r.b_re;
		d = r.b_im;
		o.res_re = '0;
		o.res_im = '0;
		o.status = STAT_OK;
		case (r.mode)
			MODE_CADD: begin
				o.res_re = clamp32(a + c, flag);
				o.res_im = clamp32(b + d, flag);
			end
			MODE_CSUB: begin
				o.res_re = clamp32(a - c, flag);
				o.res_im = clamp32(b - d, flag);
			end
			MODE_CMUL: begin
				o.res_re = round_fx(a * c - b * d, flag);
				o.res_im = round_fx(a * d + b * c, flag);
			end
			MODE_CDIV: begin
				den = c * c + d * d;
				if (den == 0) begin
					o.status = STAT_DZ;
				end else begin
					o.res_re = div_fx(a * c + b * d, den, flag);
					o.res_im = div_fx(b * c - a * d, den, flag);
				end
			end
			MODE_SADD: begin
				o.res_re = clamp32(a + c, flag);
				o.res_im = r.a_im;
			end
			MODE_SSUB: begin
				o.res_re = clamp32(a - c, flag);
				o.res_im = r.a_im;
			end
			MODE_SMUL: begin
				o.res_re = round_fx(a * c, flag);
				o.res_im = round_fx(b * c, flag);
			end
			default: begin
				if (c == 0) begin
					o.status = STAT_DZ;
				end else begin
					o.res_re = div_fx(a, c, flag);
					o.res_im = div_fx(b, c, flag);
				end
			end
		endcase
		if (o.status != STAT_DZ && flag)
			o.status = STAT_SAT;
		return o;
	endfunction

	assign pending = expected_q.size();

	// Record each accepted request and check each accepted result.
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_r;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (cmd_valid && cmd_ready)
				expected_q.push_back(predict_result(cmd));
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result re=%h im=%h st=%0d", $time,
						rsp.res_re, rsp.res_im, rsp.status);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r.res_re !== rsp.res_re || exp_r.res_im !== rsp.res_im ||
							exp_r.status !== rsp.status) begin
						$display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
							$time, exp_r.res_re, exp_r.res_im, exp_r.status,
							rsp.res_re, rsp.res_im, rsp.status);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

@@ bench/complex_arith_unit_tb.sv @@
module complex_arith_unit_tb;
	import cau_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	req_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int fail_count;
	int pending;
	bit hold_rsp = 1'b0;
	bit stim_done = 1'b0;

	always #4 clk = ~clk;

	complex_arith_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	complex_arith_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	// Operand values weighted toward the edges of the range.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return '0;
			3: return 32'h00010000;
			4: return 32'hffff0000;
			5: return $urandom_range(0, 3);
			6: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	// Present one request and wait until it is taken; valid drops only across a gap.
	task automatic send_request(input mode_t m, input logic [31:0] ar, input logic [31:0] ai,
			input logic [31:0] br, input logic [31:0] bi, input bit gaps);
		int gap;
		gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10)) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{mode: m, a_re: ar, a_im: ai, b_re: br, b_im: bi};
		do @(posedge clk); while (!cmd_ready);
	endtask

	// Result side: random stalls, or a long hold-off when asked.
	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (120) @(posedge clk);
				hold_rsp = 1'b0;
			end
			gap = (stim_done || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin
		#5000000;
		$display("complex_arith_unit_tb NOT OK");
		$finish;
	end

	initial begin
		int i;
		mode_t m;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: every mode, range extremes, division by zero, rounding ties.
		for (i = 0; i < 8; i++) begin
			m = mode_t'(i);
			send_request(m, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
		end
		send_request(MODE_CDIV, 32'h00010000, 32'h00020000, '0, '0, 0);
		send_request(MODE_SDIV, 32'h00010000, 32'h00020000, '0, 32'h00050000, 0);
		send_request(MODE_CDIV, 32'h00030000, 32'h00040000, 32'h00010000, 32'h00010000, 0);
		send_request(MODE_SDIV, 32'h00010000, 32'hffff0000, 32'h00030000, 32'h1, 0);
		send_request(MODE_SMUL, 32'h00000001, 32'hffffffff, 32'h00008000, 32'h0, 0);
		send_request(MODE_CMUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
		send_request(MODE_SADD, 32'h80000000, 32'h12345678, 32'h80000000, 32'hdeadbeef, 0);
		send_request(MODE_SSUB, 32'h7fffffff, 32'h1, 32'h80000000, 32'h0, 0);
		send_request(MODE_CDIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0, 0);
		send_request(MODE_SDIV, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h0, 0);
		send_request(MODE_CADD, 32'hffffffff, 32'h0, 32'h0, 32'hffffffff, 0);
		// Pause until the pipeline has drained.
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// Fill the pipeline while the result side holds off.
		hold_rsp = 1'b1;
		for (i = 0; i < 80; i++)
			send_request(mode_t'($urandom_range(0, 7)), pick_value(), pick_value(),
				pick_value(), pick_value(), 0);
		// Random part.
		for (i = 0; i < 850; i++)
			send_request(mode_t'($urandom_range(0, 7)), pick_value(), pick_value(),
				pick_value(), pick_value(), 1);
		cmd_valid <= 1'b0;
		stim_done = 1'b1;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("complex_arith_unit_tb OK");
		else
			$display("complex_arith_unit_tb NOT OK");
		$finish;
	end

endmodule
